// File: hdl/assert_macros.svh
// Assertion macros shared by the display controller RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NXT(lbl, clk, rstn, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hdl/clcd_pkg.sv
// Shared types and constants for the character display controller.
// No dependencies; imported by every module of the block.
package clcd_pkg;

    // Screen geometry
    localparam int ROWS   = 2;
    localparam int COLS   = 16;
    localparam int ROW_W  = 1;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 8;
    localparam int OP_W   = 3;
    localparam int CMD_W  = 4;
    localparam int TABW_W = 4;
    localparam int CELLS  = ROWS * COLS;
    localparam int CELL_W = $clog2(CELLS);

    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLS - 1);
    localparam logic [CELL_W-1:0] COLS_C   = CELL_W'(COLS);

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'd7;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_HT    = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_DC1   = 8'd17;
    localparam logic [CHAR_W-1:0] CH_DC2   = 8'd18;
    localparam logic [CHAR_W-1:0] CH_DC3   = 8'd19;
    localparam logic [CHAR_W-1:0] CH_DC4   = 8'd20;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

    // Display operations
    localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_CUR   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_LIGHT_OFF = 3'd3;
    localparam logic [OP_W-1:0] OP_LIGHT_ON  = 3'd4;
    localparam logic [OP_W-1:0] OP_CUR_OFF   = 3'd5;
    localparam logic [OP_W-1:0] OP_CUR_ON    = 3'd6;
    localparam logic [OP_W-1:0] OP_BELL      = 3'd7;

    // Classified commands passed from front to back
    localparam logic [CMD_W-1:0] CMD_PRINT = 4'd0;
    localparam logic [CMD_W-1:0] CMD_BELL  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_BACK  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RUB   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_TAB   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_LF    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FF    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CR    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_LOFF  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LON   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_COFF  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_CON   = 4'd11;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LF_RETURN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_BS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH = 2'd2;
    localparam logic [TABW_W-1:0] TAB_WIDTH_RESET = 4'd5;
    localparam logic [TABW_W-1:0] TAB_MIN         = 4'd1;
    localparam logic [TABW_W-1:0] TAB_MAX         = 4'd8;

    // Command queue sizing
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] glyph;
    } cmd_item_t;

    typedef struct packed {
        logic              lf_return;
        logic              bs_del_swap;
        logic [TABW_W-1:0] tab_width;
    } cfg_t;

endpackage

// File: hdl/clcd_front.sv
// Front end: accepts character items and classifies them into commands.
// Depends on clcd_pkg; feeds clcd_queue.
module clcd_front
    import clcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              bs_del_swap,
    output logic              push,
    output cmd_item_t         push_item,
    input  logic              q_full
);

    logic      fr_valid_reg, fr_valid_next;
    cmd_item_t fr_item_reg, fr_item_next;
    logic      accept;
    logic      keep;
    cmd_item_t cls_item;

    // Classify the incoming byte
    always_comb
    begin
        keep           = 1'b1;
        cls_item.cmd   = CMD_PRINT;
        cls_item.glyph = char_code;
        case (char_code)
            CH_NUL: keep = 1'b0;
            CH_BEL: cls_item.cmd = CMD_BELL;
            CH_BS:  cls_item.cmd = bs_del_swap ? CMD_RUB : CMD_BACK;
            CH_HT:  cls_item.cmd = CMD_TAB;
            CH_LF:  cls_item.cmd = CMD_LF;
            CH_FF:  cls_item.cmd = CMD_FF;
            CH_CR:  cls_item.cmd = CMD_CR;
            CH_DC1: cls_item.cmd = CMD_LOFF;
            CH_DC2: cls_item.cmd = CMD_LON;
            CH_DC3: cls_item.cmd = CMD_COFF;
            CH_DC4: cls_item.cmd = CMD_CON;
            CH_DEL: cls_item.cmd = bs_del_swap ? CMD_BACK : CMD_RUB;
            default: cls_item.cmd = CMD_PRINT;
        endcase
    end

    // Holding stage in front of the queue
    assign in_stall  = fr_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = fr_valid_reg && !q_full;
    assign push_item = fr_item_reg;

    always_comb
    begin
        fr_valid_next = fr_valid_reg && !push;
        fr_item_next  = fr_item_reg;
        if (accept)
        begin
            fr_valid_next = keep;
            fr_item_next  = cls_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_item_reg <= fr_item_next;
    end

endmodule

// File: hdl/clcd_queue.sv
// Short command queue between the classifying front and the executing back.
// Depends on clcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clcd_queue
    import clcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output cmd_item_t pop_item
);

    cmd_item_t            q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = q_mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_NEVER(a_q_push_full, clk, rst_n, push && full)
    `ASSERT_NEVER(a_q_pop_empty, clk, rst_n, pop && !pop_valid)

endmodule

// File: hdl/clcd_back.sv
// Back end: runs queued commands, keeps cursor and screen text, and issues
// display operations through an output register. Depends on clcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clcd_back
    import clcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  cmd_item_t         q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [OP_W-1:0]   display_op,
    output logic [ROW_W-1:0]  target_row,
    output logic [COL_W-1:0]  target_col,
    output logic [CHAR_W-1:0] glyph,
    output logic              last_of_run
);

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_SIMPLE = 4'd1;
    localparam logic [ST_W-1:0] ST_BACK   = 4'd2;
    localparam logic [ST_W-1:0] ST_RUB1   = 4'd3;
    localparam logic [ST_W-1:0] ST_PWRITE = 4'd4;
    localparam logic [ST_W-1:0] ST_RUB2   = 4'd5;
    localparam logic [ST_W-1:0] ST_TMOD   = 4'd6;
    localparam logic [ST_W-1:0] ST_LFRET  = 4'd7;
    localparam logic [ST_W-1:0] ST_CR     = 4'd8;
    localparam logic [ST_W-1:0] ST_ADV    = 4'd9;
    localparam logic [ST_W-1:0] ST_SCLR   = 4'd10;
    localparam logic [ST_W-1:0] ST_SSCAN  = 4'd11;
    localparam logic [ST_W-1:0] ST_SCUR   = 4'd12;
    localparam logic [ST_W-1:0] ST_FCUR   = 4'd13;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [CHAR_W-1:0] pglyph_reg, pglyph_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  tmod_reg, tmod_next;
    logic [ROW_W-1:0]  scan_row_reg, scan_row_next;
    logic [COL_W-1:0]  scan_col_reg, scan_col_next;
    logic [CHAR_W-1:0] screen_reg [CELLS];
    logic [CHAR_W-1:0] screen_next [CELLS];

    logic              out_valid_reg, out_valid_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ROW_W-1:0]  trow_reg, trow_next;
    logic [COL_W-1:0]  tcol_reg, tcol_next;
    logic [CHAR_W-1:0] oglyph_reg, oglyph_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              emit;
    logic [OP_W-1:0]   e_op;
    logic [ROW_W-1:0]  e_row;
    logic [COL_W-1:0]  e_col;
    logic [CHAR_W-1:0] e_glyph;
    logic              e_last;
    logic [TABW_W-1:0] tw_sat;
    logic [COL_W-1:0]  tw_col;
    logic [CELL_W-1:0] wr_idx;
    logic [CELL_W-1:0] scan_idx;

    // Op code for commands that give a single fixed operation
    function automatic logic [OP_W-1:0] simple_op(input logic [CMD_W-1:0] c);
        logic [OP_W-1:0] op;
        case (c)
            CMD_FF:   op = OP_CLEAR;
            CMD_LOFF: op = OP_LIGHT_OFF;
            CMD_LON:  op = OP_LIGHT_ON;
            CMD_COFF: op = OP_CUR_OFF;
            CMD_CON:  op = OP_CUR_ON;
            default:  op = OP_BELL;
        endcase
        return op;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    // Tab width clamped to 1..8
    always_comb
    begin
        if (cfg.tab_width < TAB_MIN)
        begin
            tw_sat = TAB_MIN;
        end
        else if (cfg.tab_width > TAB_MAX)
        begin
            tw_sat = TAB_MAX;
        end
        else
        begin
            tw_sat = cfg.tab_width;
        end
    end
    assign tw_col = COL_W'(tw_sat);

    assign wr_idx   = CELL_W'(row_reg) * COLS_C + CELL_W'(col_reg);
    assign scan_idx = CELL_W'(scan_row_reg) * COLS_C + CELL_W'(scan_col_reg);

    // Command sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pglyph_next   = pglyph_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        tmod_next     = tmod_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        for (int i = 0; i < CELLS; i++)
        begin
            screen_next[i] = screen_reg[i];
        end
        q_pop   = 1'b0;
        emit    = 1'b0;
        e_op    = OP_WRITE;
        e_row   = '0;
        e_col   = '0;
        e_glyph = '0;
        e_last  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_item.cmd;
                    pglyph_next = q_item.glyph;
                    case (q_item.cmd)
                        CMD_PRINT: state_next = ST_PWRITE;
                        CMD_BACK:  state_next = ST_BACK;
                        CMD_RUB:
                        begin
                            pglyph_next = CH_SPACE;
                            state_next  = ST_RUB1;
                        end
                        CMD_TAB:
                        begin
                            pglyph_next = CH_SPACE;
                            tmod_next   = col_reg;
                            state_next  = ST_TMOD;
                        end
                        CMD_LF:    state_next = cfg.lf_return ? ST_LFRET : ST_ADV;
                        CMD_CR:    state_next = ST_CR;
                        default:   state_next = ST_SIMPLE;
                    endcase
                end
            end

            // Bell, clear, light and cursor switches
            ST_SIMPLE:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    e_op   = simple_op(cmd_reg);
                    e_last = 1'b1;
                    if (cmd_reg == CMD_FF)
                    begin
                        for (int i = 0; i < CELLS; i++)
                        begin
                            screen_next[i] = '0;
                        end
                        row_next = '0;
                        col_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            // Backspace, alone or as the final step of a rub-out
            ST_BACK, ST_RUB2:
            begin
                if (col_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    e_op       = OP_SET_CUR;
                    e_row      = row_reg;
                    e_col      = col_reg - COL_W'(1);
                    e_last     = 1'b1;
                    col_next   = col_reg - COL_W'(1);
                    state_next = ST_IDLE;
                end
            end

            // First backspace of a rub-out
            ST_RUB1:
            begin
                if (col_reg == '0)
                begin
                    state_next = ST_PWRITE;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    e_op       = OP_SET_CUR;
                    e_row      = row_reg;
                    e_col      = col_reg - COL_W'(1);
                    col_next   = col_reg - COL_W'(1);
                    state_next = ST_PWRITE;
                end
            end

            // Remainder of the column by the tab width, one subtract a cycle, then spaces to the next stop
            ST_TMOD:
            begin
                if (tmod_reg >= tw_col)
                begin
                    tmod_next = tmod_reg - tw_col;
                end
                else
                begin
                    tmod_next  = tw_col - tmod_reg;
                    state_next = ST_PWRITE;
                end
            end

            // Write one glyph at the cursor
            ST_PWRITE:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    e_op    = OP_WRITE;
                    e_row   = row_reg;
                    e_col   = col_reg;
                    e_glyph = pglyph_reg;
                    screen_next[wr_idx] = pglyph_reg;
                    if (col_reg >= LAST_COL)
                    begin
                        col_next   = '0;
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                        case (cmd_reg)
                            CMD_TAB:
                            begin
                                if (tmod_reg == COL_W'(1))
                                begin
                                    e_last     = 1'b1;
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    tmod_next = tmod_reg - COL_W'(1);
                                end
                            end
                            CMD_RUB: state_next = ST_RUB2;
                            default:
                            begin
                                e_last     = 1'b1;
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            // Return before a line feed
            ST_LFRET:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_op       = OP_SET_CUR;
                    e_row      = row_reg;
                    col_next   = '0;
                    state_next = ST_ADV;
                end
            end

            ST_CR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_op       = OP_SET_CUR;
                    e_row      = row_reg;
                    e_last     = 1'b1;
                    col_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            // Next row, or scroll at the bottom row
            ST_ADV:
            begin
                if (row_reg < LAST_ROW)
                begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = ST_FCUR;
                end
                else
                begin
                    state_next = ST_SCLR;
                end
            end

            // Scroll: clear, shift the buffer up and blank the bottom row
            ST_SCLR:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    e_op = OP_CLEAR;
                    for (int i = 0; i < CELLS - COLS; i++)
                    begin
                        screen_next[i] = screen_reg[i + COLS];
                    end
                    for (int i = CELLS - COLS; i < CELLS; i++)
                    begin
                        screen_next[i] = '0;
                    end
                    scan_row_next = '0;
                    scan_col_next = '0;
                    state_next    = ST_SSCAN;
                end
            end

            // Redraw every position in row-major order
            ST_SSCAN:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    e_op    = OP_WRITE;
                    e_row   = scan_row_reg;
                    e_col   = scan_col_reg;
                    e_glyph = screen_reg[scan_idx];
                    if (scan_col_reg >= LAST_COL)
                    begin
                        scan_col_next = '0;
                        if (scan_row_reg >= LAST_ROW)
                        begin
                            state_next = ST_SCUR;
                        end
                        else
                        begin
                            scan_row_next = scan_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        scan_col_next = scan_col_reg + COL_W'(1);
                    end
                end
            end

            // Cursor restore ending the scroll
            ST_SCUR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_op       = OP_SET_CUR;
                    e_row      = row_reg;
                    e_col      = col_reg;
                    state_next = ST_FCUR;
                end
            end

            // Final cursor placement after a row advance
            ST_FCUR:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_op       = OP_SET_CUR;
                    e_row      = row_reg;
                    e_col      = col_reg;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_free ? emit : out_valid_reg;
        op_next        = op_reg;
        trow_next      = trow_reg;
        tcol_next      = tcol_reg;
        oglyph_next    = oglyph_reg;
        last_next      = last_reg;
        if (emit)
        begin
            op_next     = e_op;
            trow_next   = e_row;
            tcol_next   = e_col;
            oglyph_next = e_glyph;
            last_next   = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CELLS; i++)
            begin
                screen_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CELLS; i++)
            begin
                screen_reg[i] <= screen_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pglyph_reg   <= pglyph_next;
        tmod_reg     <= tmod_next;
        scan_row_reg <= scan_row_next;
        scan_col_reg <= scan_col_next;
        op_reg       <= op_next;
        trow_reg     <= trow_next;
        tcol_reg     <= tcol_next;
        oglyph_reg   <= oglyph_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign display_op  = op_reg;
    assign target_row  = trow_reg;
    assign target_col  = tcol_reg;
    assign glyph       = oglyph_reg;
    assign last_of_run = last_reg;

    `ASSERT_NEVER(a_col_range, clk, rst_n, col_reg > LAST_COL)
    `ASSERT_NXT(a_last_ends_run, clk, rst_n, emit && e_last, state_reg == ST_IDLE)
    `ASSERT_NEVER(a_pop_busy, clk, rst_n, q_pop && (state_reg != ST_IDLE))

endmodule

// File: hdl/char_lcd_terminal_control_top.sv
// Path: an accepted byte is held in the front register, then written into the command queue;
// the sequencer pops it when idle and presents its display operations through the output register.
// Throughput: at most one operation per unstalled cycle; a byte gives up to 43 operations (a tab
// wrapping into a scroll), and a tab first runs column / tab width + 1 remainder steps. The pop,
// row advance steps and a backspace at column 0 issue no operation. Reset: cursor at row 0
// column 0, text zeroed, options off, tab width 5. Uses clcd_pkg, front, queue and back.
module char_lcd_terminal_control_top
    import clcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TABW_W-1:0]    cfg_data,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OP_W-1:0]      display_op,
    output logic [ROW_W-1:0]     target_row,
    output logic [COL_W-1:0]     target_col,
    output logic [CHAR_W-1:0]    glyph,
    output logic                 last_of_run
);

    cfg_t      cfg_reg, cfg_next;
    logic      push;
    cmd_item_t push_item;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    cmd_item_t q_item;

    // Option registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LF_RETURN: cfg_next.lf_return   = cfg_data[0];
                CFG_SWAP_BS:   cfg_next.bs_del_swap = cfg_data[0];
                CFG_TAB_WIDTH: cfg_next.tab_width   = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lf_return   <= 1'b0;
            cfg_reg.bs_del_swap <= 1'b0;
            cfg_reg.tab_width   <= TAB_WIDTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clcd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bs_del_swap (cfg_reg.bs_del_swap),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    clcd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    clcd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .display_op  (display_op),
        .target_row  (target_row),
        .target_col  (target_col),
        .glyph       (glyph),
        .last_of_run (last_of_run)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_terminal_control_top: holds a scoreboard class that
// tracks cursor, text buffer and options and predicts every display command per byte.
// Depends on clcd_pkg and the top-level RTL only.
module testbench;
    import clcd_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;

    // One display command as seen on the output port
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } disp_cmd_t;

    // Terminal state tracker and display command checker
    class lcd_scoreboard;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic [CHAR_W-1:0] text [CELLS];
        logic              lf_return;
        logic              bs_del_swap;
        logic [TABW_W-1:0] tab_width;
        disp_cmd_t         pending_cmds[$];
        int                errors;

        function new();
            cur_row     = '0;
            cur_col     = '0;
            foreach (text[i]) text[i] = '0;
            lf_return   = 1'b0;
            bs_del_swap = 1'b0;
            tab_width   = TAB_WIDTH_RESET;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TABW_W-1:0] val);
            case (idx)
                CFG_LF_RETURN: lf_return   = val[0];
                CFG_SWAP_BS:   bs_del_swap = val[0];
                CFG_TAB_WIDTH: tab_width   = val;
                default: ;
            endcase
        endfunction

        function void push_cmd(logic [OP_W-1:0] op, logic [ROW_W-1:0] r,
                               logic [COL_W-1:0] c, logic [CHAR_W-1:0] g);
            disp_cmd_t cmd;
            cmd = '{op: op, row: r, col: c, ch: g, last: 1'b0};
            pending_cmds.push_back(cmd);
        endfunction

        function void cursor_cmd();
            push_cmd(OP_SET_CUR, cur_row, cur_col, '0);
        endfunction

        // Shift rows up, blank the bottom row, redraw everything
        function void shift_text_up();
            for (int i = 0; i < CELLS - COLS; i++)
                text[i] = text[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                text[i] = '0;
            push_cmd(OP_CLEAR, '0, '0, '0);
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++)
                    push_cmd(OP_WRITE, ROW_W'(r), COL_W'(c), text[r * COLS + c]);
            cursor_cmd();
        endfunction

        function void print_glyph(logic [CHAR_W-1:0] g);
            text[int'(cur_row) * COLS + int'(cur_col)] = g;
            push_cmd(OP_WRITE, cur_row, cur_col, g);
            if (int'(cur_col) >= COLS - 1) begin
                cur_col = '0;
                if (int'(cur_row) >= ROWS - 1)
                    shift_text_up();
                else
                    cur_row = cur_row + 1'b1;
                cursor_cmd();
            end
            else begin
                cur_col = cur_col + 1'b1;
            end
        endfunction

        function void step_back();
            if (cur_col != '0) begin
                cur_col = cur_col - 1'b1;
                cursor_cmd();
            end
        endfunction

        function void rub_out();
            step_back();
            print_glyph(CH_SPACE);
            step_back();
        endfunction

        function void line_feed();
            if (lf_return) begin
                cur_col = '0;
                cursor_cmd();
            end
            if (int'(cur_row) < ROWS - 1)
                cur_row = cur_row + 1'b1;
            else
                shift_text_up();
            cursor_cmd();
        endfunction

        // Predict the run of display commands for one accepted byte
        function void note_char(logic [CHAR_W-1:0] c);
            int        run_start;
            int        tw;
            disp_cmd_t tail;
            run_start = pending_cmds.size();
            case (c)
                CH_NUL: ;
                CH_BEL: push_cmd(OP_BELL, '0, '0, '0);
                CH_BS:  if (bs_del_swap) rub_out(); else step_back();
                CH_HT: begin
                    // out-of-range widths clamp to 1..8
                    tw = int'(tab_width);
                    if (tw < int'(TAB_MIN)) tw = int'(TAB_MIN);
                    if (tw > int'(TAB_MAX)) tw = int'(TAB_MAX);
                    do
                        print_glyph(CH_SPACE);
                    while ((int'(cur_col) % tw) != 0);
                end
                CH_LF:  line_feed();
                CH_FF: begin
                    push_cmd(OP_CLEAR, '0, '0, '0);
                    foreach (text[i]) text[i] = '0;
                    cur_row = '0;
                    cur_col = '0;
                end
                CH_CR: begin
                    cur_col = '0;
                    cursor_cmd();
                end
                CH_DC1: push_cmd(OP_LIGHT_OFF, '0, '0, '0);
                CH_DC2: push_cmd(OP_LIGHT_ON, '0, '0, '0);
                CH_DC3: push_cmd(OP_CUR_OFF, '0, '0, '0);
                CH_DC4: push_cmd(OP_CUR_ON, '0, '0, '0);
                CH_DEL: if (bs_del_swap) step_back(); else rub_out();
                default: print_glyph(c);
            endcase
            if (pending_cmds.size() > run_start) begin
                tail = pending_cmds.pop_back();
                tail.last = 1'b1;
                pending_cmds.push_back(tail);
            end
        endfunction

        function void check_result(disp_cmd_t got);
            disp_cmd_t want;
            if (pending_cmds.size() == 0) begin
                $error("unexpected display command: op %0d row %0d col %0d glyph %0d last %0d",
                       got.op, got.row, got.col, got.ch, got.last);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            if (got.op !== want.op) begin
                $error("display_op: expected %0d, got %0d", want.op, got.op);
                errors++;
            end
            if (got.row !== want.row) begin
                $error("target_row: expected %0d, got %0d", want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("target_col: expected %0d, got %0d", want.col, got.col);
                errors++;
            end
            if (got.ch !== want.ch) begin
                $error("glyph: expected %0d, got %0d", want.ch, got.ch);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TABW_W-1:0]    cfg_data;
    logic [CHAR_W-1:0]    char_code;
    logic                 in_valid;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall;
    logic [OP_W-1:0]      display_op;
    logic [ROW_W-1:0]     target_row;
    logic [COL_W-1:0]     target_col;
    logic [CHAR_W-1:0]    glyph;
    logic                 last_of_run;

    lcd_scoreboard sb;
    bit            hold_req;

    char_lcd_terminal_control_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .char_code   (char_code),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .display_op  (display_op),
        .target_row  (target_row),
        .target_col  (target_col),
        .glyph       (glyph),
        .last_of_run (last_of_run)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Monitor: inputs accepted and commands delivered at the rising edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && sb != null) begin
            if (in_valid && !in_stall)
                sb.note_char(char_code);
            if (out_valid && !out_stall)
                sb.check_result('{op: display_op, row: target_row, col: target_col,
                                  ch: glyph, last: last_of_run});
        end
    end

    // Receiver: stall modes that change after a random run, plus a long hold on request
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            tick++;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ((tick % 7) < 3);
                default: out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    // Offer one byte and hold it until accepted; returns at the following falling edge
    task automatic send_char(input logic [CHAR_W-1:0] c);
        char_code <= c;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Let the block go quiet, including bytes that give no command
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic lf_ret, input logic swap,
                                input logic [TABW_W-1:0] tw);
        logic [TABW_W-1:0] vals [3];
        logic [CFG_IDX_W-1:0] idxs [3];
        vals = '{TABW_W'(lf_ret), TABW_W'(swap), tw};
        idxs = '{CFG_LF_RETURN, CFG_SWAP_BS, CFG_TAB_WIDTH};
        for (int i = 0; i < 3; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            sb.set_reg(idxs[i], vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly text so the screen fills and scrolls, with control codes mixed in
    function automatic logic [CHAR_W-1:0] pick_char();
        int b;
        b = $urandom_range(0, 99);
        if (b < 52)      return CHAR_W'($urandom_range(32, 126));
        else if (b < 60) return CHAR_W'($urandom_range(0, 255));
        else if (b < 68) return CH_LF;
        else if (b < 73) return CH_CR;
        else if (b < 79) return CH_HT;
        else if (b < 85) return CH_BS;
        else if (b < 90) return CH_DEL;
        else if (b < 93) return CHAR_W'($urandom_range(17, 20));
        else if (b < 95) return CH_BEL;
        else if (b < 97) return CH_FF;
        else             return CH_NUL;
    endfunction

    // Random bytes in bursts with random gaps, exactly n bytes in all
    task automatic send_random(input int n);
        int                count;
        int                burst;
        int                gap;
        logic [CHAR_W-1:0] c;
        count = 0;
        while (count < n)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && count < n; k++)
            begin
                c = pick_char();
                send_char(c);
                count++;
            end
            gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        logic [CHAR_W-1:0] directed [$];
        sb        = new();
        hold_req  = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        char_code = '0;
        in_valid  = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed bytes at reset options: ignored byte, bell, back/delete at column
        // zero, text extremes, other control codes printed, cursor moves, light and
        // cursor switches, form feed, then tabs that wrap into a scroll and a line
        // feed on the bottom row
        directed = '{CH_NUL, CH_BEL, CH_BS, CH_DEL, 8'h41, CH_BS, CH_DEL, 8'hFF,
                     8'h80, 8'h01, 8'h1F, CH_HT, CH_LF, CH_CR, CH_DC1, CH_DC2,
                     CH_DC3, CH_DC4, CH_FF, CH_LF, CH_HT, CH_HT, CH_HT, CH_HT, CH_LF};
        foreach (directed[i]) send_char(directed[i]);
        wait_idle();

        write_config(1'b1, 1'b1, TAB_MIN);
        send_random(48);
        wait_idle();

        // Long output hold while bytes keep coming so the input backs up
        write_config(1'b0, 1'b1, TAB_MAX);
        hold_req = 1'b1;
        send_random(48);
        wait_idle();

        write_config(1'b1, 1'b0, 4'd0);
        send_random(48);
        wait_idle();

        write_config(1'b0, 1'b0, 4'd15);
        send_random(48);
        wait_idle();

        repeat (2)
        begin
            write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         TABW_W'($urandom_range(0, 15)));
            send_random(48);
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending_cmds.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: char_lcd_terminal_control_top.f
+incdir+hdl
hdl/clcd_pkg.sv
hdl/clcd_front.sv
hdl/clcd_queue.sv
hdl/clcd_back.sv
hdl/char_lcd_terminal_control_top.sv
sim/testbench.sv
